### src/rmq_pkg.sv
// Package with constants and the pipeline word type of the rotation matrix to quaternion unit.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int FracBits   = 14;
  localparam int InW        = 16;
  localparam int VecW       = 19;               // signed width of the branch vector
  localparam int MagW       = 17;               // magnitude of one vector part
  localparam int SqW        = 2 * MagW;         // one square
  localparam int SumW       = SqW + 2;          // sum of four squares
  localparam int RootW      = SumW / 2;         // integer square root
  localparam int RemW       = RootW + 2;        // square root remainder
  localparam int QuotW      = FracBits + 1;     // quotient holds up to ONE
  localparam int NumW       = MagW + FracBits + 1;
  localparam int DremW      = RootW;            // divider remainder, always below len
  localparam int SqrtFirst  = 3;
  localparam int DivPrep    = SqrtFirst + RootW;
  localparam int DivFirst   = DivPrep + 1;
  localparam int OutStage   = DivFirst + QuotW;
  localparam int NumStages  = OutStage + 1;
  localparam int One        = 1 << FracBits;
  localparam int ThreshNum  = 1000;
  localparam int ThreshDen  = 1001;
  localparam int ProdW      = VecW + 11;

  typedef struct packed {
    logic                          deg;
    logic [3:0]                    neg;
    logic [3:0][MagW-1:0]          mag;
    logic [3:0][SqW-1:0]           sq;
    logic [SumW-1:0]               acc;
    logic [RemW-1:0]               srem;
    logic [RootW-1:0]              root;
    logic [3:0][DremW-1:0]         drem;
    logic [3:0][QuotW-1:0]         dlow;
  } pipe_t;

endpackage

### src/rotation_matrix_to_quaternion_unit.sv
// Top level: pipelined rotation matrix to unit quaternion converter.
`timescale 1ns / 1ps
// Takes one 3x3 rotation matrix word per cycle (nine signed Q1.14 entries) while
// the output side does not stall and returns the unit quaternion in Q1.14. The
// pipeline holds the 18 stages of the bit-serial integer square root and the
// 15 stages of the four parallel restoring dividers.
// Each stage has its own valid bit and holds its word under backpressure, so
// bubbles are squeezed out and nothing is lost or repeated. When the selected
// radicand is not positive or the vector length is zero, the four parts are
// zero and tuser carries the degenerate flag.
module rotation_matrix_to_quaternion_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
  // row2_col0, row2_col1, row2_col2 from the lowest bit up, 16 bits each.
  input  logic [143:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // w_part, x_part, y_part, z_part from the lowest bit up, 16 bits each.
  output logic [63:0]  m_axis_tdata_o,
  // degenerate.
  output logic         m_axis_tuser_o
);
  import rmq_pkg::*;

  pipe_t                pipe_q [NumStages];
  pipe_t                pipe_d [NumStages];
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;
  logic [NumStages-1:0] in_valid;

  assign ready[NumStages] = m_axis_tready_i;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    assign ready[k] = !valid_q[k] || ready[k+1];
    if (k == 0) begin : g_first
      assign in_valid[k] = s_axis_tvalid_i;
    end else begin : g_next
      assign in_valid[k] = valid_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= in_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k] && in_valid[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Stage 0: branch choice and the unnormalized vector.
  logic signed [VecW-1:0]  m [9];
  logic signed [VecW-1:0]  tr, rad, vec [4];
  logic signed [ProdW-1:0] lhs;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = VecW'(signed'(s_axis_tdata_i[16*i +: InW]));
    end
    tr  = VecW'(One) + m[0] + m[4] + m[8];
    lhs = ProdW'(tr) * ProdW'(ThreshNum);
    if (lhs > ProdW'(ThreshDen * One)) begin
      rad    = tr;
      vec[0] = rad;         vec[1] = m[7] - m[5];
      vec[2] = m[2] - m[6]; vec[3] = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      rad    = VecW'(One) + m[0] - m[4] - m[8];
      vec[0] = m[7] - m[5]; vec[1] = rad;
      vec[2] = m[1] + m[3]; vec[3] = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      rad    = VecW'(One) + m[4] - m[0] - m[8];
      vec[0] = m[2] - m[6]; vec[1] = m[1] + m[3];
      vec[2] = rad;         vec[3] = m[5] + m[7];
    end else begin
      rad    = VecW'(One) + m[8] - m[0] - m[4];
      vec[0] = m[3] - m[1]; vec[1] = m[2] + m[6];
      vec[2] = m[5] + m[7]; vec[3] = rad;
    end
    pipe_d[0]     = '0;
    pipe_d[0].deg = (rad <= 0);
    for (int i = 0; i < 4; i++) begin
      pipe_d[0].neg[i] = vec[i][VecW-1];
      pipe_d[0].mag[i] = vec[i][VecW-1] ? MagW'(-vec[i]) : MagW'(vec[i]);
    end
  end

  // Stage 1: squares.
  always_comb begin
    pipe_d[1] = pipe_q[0];
    for (int i = 0; i < 4; i++) begin
      pipe_d[1].sq[i] = SqW'(pipe_q[0].mag[i]) * SqW'(pipe_q[0].mag[i]);
    end
  end

  // Stage 2: sum of squares, then the root starts from zero.
  always_comb begin
    pipe_d[2]      = pipe_q[1];
    pipe_d[2].acc  = SumW'(pipe_q[1].sq[0]) + SumW'(pipe_q[1].sq[1]) +
                     SumW'(pipe_q[1].sq[2]) + SumW'(pipe_q[1].sq[3]);
    pipe_d[2].srem = '0;
    pipe_d[2].root = '0;
  end

  // Square root: one result bit per stage, most significant first.
  for (genvar k = SqrtFirst; k < DivPrep; k++) begin : g_sqrt
    localparam int Bit = RootW - 1 - (k - SqrtFirst);
    logic [RemW+1:0] cur, trial;
    always_comb begin
      pipe_d[k] = pipe_q[k-1];
      cur   = {pipe_q[k-1].srem, pipe_q[k-1].acc[2*Bit +: 2]};
      trial = {2'b00, pipe_q[k-1].root, 2'b01};
      if (cur >= trial) begin
        pipe_d[k].srem = RemW'(cur - trial);
        pipe_d[k].root = {pipe_q[k-1].root[RootW-2:0], 1'b1};
      end else begin
        pipe_d[k].srem = RemW'(cur);
        pipe_d[k].root = {pipe_q[k-1].root[RootW-2:0], 1'b0};
      end
    end
  end

  // Dividend with half the length added for rounding.
  logic [NumW-1:0] num [4];
  always_comb begin
    pipe_d[DivPrep] = pipe_q[DivPrep-1];
    if (pipe_q[DivPrep-1].root == '0) begin
      pipe_d[DivPrep].deg = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      num[i] = NumW'({pipe_q[DivPrep-1].mag[i], FracBits'(0)}) +
               NumW'(pipe_q[DivPrep-1].root >> 1);
      pipe_d[DivPrep].drem[i] = DremW'(num[i][NumW-1:QuotW]);
      pipe_d[DivPrep].dlow[i] = num[i][QuotW-1:0];
    end
  end

  // Restoring division, four lanes, one quotient bit per stage.
  for (genvar k = DivFirst; k < OutStage; k++) begin : g_div
    logic [DremW:0] part [4];
    always_comb begin
      pipe_d[k] = pipe_q[k-1];
      for (int i = 0; i < 4; i++) begin
        part[i] = {pipe_q[k-1].drem[i], pipe_q[k-1].dlow[i][QuotW-1]};
        if (part[i] >= {1'b0, pipe_q[k-1].root}) begin
          pipe_d[k].drem[i] = DremW'(part[i] - {1'b0, pipe_q[k-1].root});
          pipe_d[k].dlow[i] = {pipe_q[k-1].dlow[i][QuotW-2:0], 1'b1};
        end else begin
          pipe_d[k].drem[i] = DremW'(part[i]);
          pipe_d[k].dlow[i] = {pipe_q[k-1].dlow[i][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  // Output stage: clamp, sign and the degenerate case. Each part is kept in the
  // low bits of its lane of sq.
  logic [QuotW-1:0] qc [4];
  logic [InW-1:0]   part_out [4];
  always_comb begin
    pipe_d[OutStage] = pipe_q[OutStage-1];
    for (int i = 0; i < 4; i++) begin
      qc[i] = (pipe_q[OutStage-1].dlow[i] > QuotW'(One)) ? QuotW'(One)
                                                        : pipe_q[OutStage-1].dlow[i];
      if (pipe_q[OutStage-1].deg) begin
        part_out[i] = '0;
      end else if (pipe_q[OutStage-1].neg[i]) begin
        part_out[i] = InW'(-{1'b0, qc[i]});
      end else begin
        part_out[i] = InW'(qc[i]);
      end
      pipe_d[OutStage].sq[i] = SqW'(part_out[i]);
    end
  end

  assign s_axis_tready_o = ready[0];
  assign m_axis_tvalid_o = valid_q[NumStages-1];
  assign m_axis_tdata_o  = {pipe_q[NumStages-1].sq[3][InW-1:0],
                            pipe_q[NumStages-1].sq[2][InW-1:0],
                            pipe_q[NumStages-1].sq[1][InW-1:0],
                            pipe_q[NumStages-1].sq[0][InW-1:0]};
  assign m_axis_tuser_o  = pipe_q[NumStages-1].deg;

`ifndef NO_ASSERTIONS
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("degenerate word with nonzero parts");
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while output side is free");
  a_w_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[15:0]) <= One &&
                        $signed(m_axis_tdata_o[15:0]) >= -One)
    else $error("w part out of range");
  a_x_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[31:16]) <= One &&
                        $signed(m_axis_tdata_o[31:16]) >= -One)
    else $error("x part out of range");
`endif

endmodule
